// ===== src/heater_pid_onoff_regulator_top_macros.svh =====
// Assertion macros for the heater regulator top level.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef HEATER_PID_ONOFF_REGULATOR_TOP_MACROS_SVH
`define HEATER_PID_ONOFF_REGULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hpid_pkg.sv =====
// Shared types and constants of the heater PID / on-off regulator.
// No dependencies; imported by every module of the block.
package hpid_pkg;

  localparam int TEMP_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int CMD_W     = 15;
  localparam int E_W       = 17;
  localparam int S_W       = 35;
  localparam int S_LO_W    = 18;
  localparam int S_HI_W    = S_W - S_LO_W;
  localparam int PROD_W    = 34;
  localparam int TOTAL_W   = 53;
  localparam int ROUND_W   = 23;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_ON_OFF = 15'd10240;
  localparam logic [CMD_W-1:0] CMD_MAX    = 15'd25600;

  localparam logic signed [TOTAL_W-1:0] FULL_Q16 = 53'sd6553600;
  localparam logic [ROUND_W:0]          ROUND_HALF = 24'd128;

  localparam logic signed [TEMP_W-1:0] SETPOINT_RST = 16'sd5120;
  localparam logic [GAIN_W-1:0]        GAIN_P_RST   = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_SETPOINT = 3'd1,
    CFG_GAIN_P   = 3'd2,
    CFG_GAIN_I   = 3'd3,
    CFG_GAIN_D   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [E_W-1:0] e;
    logic signed [E_W-1:0] d;
    logic signed [S_W-1:0] s;
  } stg1_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] pe;
    logic signed [PROD_W-1:0] pd;
    logic [PROD_W-1:0]        pil;
    logic signed [PROD_W-1:0] pih;
  } prod_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gp;
    logic [GAIN_W-1:0] gi;
    logic [GAIN_W-1:0] gd;
  } gains_t;

endpackage

// ===== src/heater_pid_onoff_regulator_top.sv =====
// Heater regulator: one temperature sample in, one heater command out.
// Depends on hpid_pkg, hpid_product and the assertion macro header.
//
// The in_ channel takes signed Q8.8 room temperatures, the out_ channel gives
// the heater command in unsigned Q7.8 percent, one result per sample, in
// order. The cfg_ channel writes mode, setpoint and the three gains; it is
// always ready. The user must write it only while no transaction is in
// flight; the block itself does not enforce this. An accepted sample passes
// through temp0_r, stg1_r, prod_r, total_r and out_command_r in order; this
// five-register pipeline takes one sample per cycle unless the receiver
// stalls. The saturating error sum is the feedback loop that sets this rate,
// and the integral product is split into two partial products. Each stage
// holds its item while the stage after it is full and stalled, so a stalled
// receiver fills the pipeline before in_ready drops. The synchronous reset
// empties the pipeline, clears the error sum and the previous sample, and
// loads on/off mode, a 20 degree setpoint and unit proportional gain.
`include "heater_pid_onoff_regulator_top_macros.svh"

module heater_pid_onoff_regulator_top import hpid_pkg::*; #(
  parameter int ACC_WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TEMP_W-1:0] in_temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CMD_W-1:0]         out_command,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  localparam int EXT_W = (ACC_WIDTH > S_W) ? ACC_WIDTH : S_W;
  localparam logic signed [EXT_W-1:0] S_MAX = EXT_W'((64'sd1 <<< (S_W - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] S_MIN = ~S_MAX;
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

  logic                     mode_r;
  logic signed [TEMP_W-1:0] setpoint_r;
  gains_t                   gains_r;

  logic                        v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic                        rdy0, rdy1, rdy2, rdy3, rdy_out, adv0;
  logic signed [TEMP_W-1:0]    temp0_r;
  logic signed [TEMP_W-1:0]    prev_temp_r;
  logic                        have_prev_r;
  logic signed [ACC_WIDTH-1:0] err_sum_r, err_sum_nxt;
  logic signed [ACC_WIDTH:0]   sum_wide;
  logic signed [EXT_W-1:0]     sum_ext;
  logic signed [E_W-1:0]       e_cur;
  stg1_t                       stg1_r, stg1_nxt;
  logic                        pos1_r, pos2_r, pos3_r, pos_nxt;
  prod_t                       prod_r;
  logic signed [TOTAL_W-1:0]   total_r, total_nxt;
  logic [ROUND_W:0]            rnd;
  logic [CMD_W-1:0]            out_command_r, cmd_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      setpoint_r <= SETPOINT_RST;
      gains_r.gp <= GAIN_P_RST;
      gains_r.gi <= '0;
      gains_r.gd <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_data[0];
        CFG_SETPOINT: setpoint_r <= $signed(cfg_data);
        CFG_GAIN_P:   gains_r.gp <= cfg_data;
        CFG_GAIN_I:   gains_r.gi <= cfg_data;
        CFG_GAIN_D:   gains_r.gd <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign adv0     = v0_r && rdy1;
  assign in_ready = rdy0;

  always_comb begin
    e_cur = E_W'(setpoint_r) - E_W'(temp0_r);
    pos_nxt = !e_cur[E_W-1] && (e_cur != '0);
    stg1_nxt.e = e_cur;
    stg1_nxt.d = have_prev_r ? (E_W'(prev_temp_r) - E_W'(temp0_r)) : '0;
    sum_wide = {err_sum_r[ACC_WIDTH-1], err_sum_r} + (ACC_WIDTH + 1)'(e_cur);
    if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
      err_sum_nxt = sum_wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
    end else begin
      err_sum_nxt = sum_wide[ACC_WIDTH-1:0];
    end
    sum_ext = EXT_W'(err_sum_nxt);
    priority if (sum_ext > S_MAX) begin
      stg1_nxt.s = S_MAX[S_W-1:0];
    end else if (sum_ext < S_MIN) begin
      stg1_nxt.s = S_MIN[S_W-1:0];
    end else begin
      stg1_nxt.s = sum_ext[S_W-1:0];
    end
  end

  always_comb begin
    total_nxt = TOTAL_W'(prod_r.pe) + TOTAL_W'(prod_r.pd)
              + TOTAL_W'({1'b0, prod_r.pil}) + (TOTAL_W'(prod_r.pih) <<< S_LO_W);
  end

  always_comb begin
    rnd = total_r[ROUND_W-1:0] + ROUND_HALF;
    priority if (!pos3_r) begin
      cmd_nxt = '0;
    end else if (!mode_r) begin
      cmd_nxt = CMD_ON_OFF;
    end else if (total_r[TOTAL_W-1] || (total_r == '0)) begin
      cmd_nxt = '0;
    end else if (total_r >= FULL_Q16) begin
      cmd_nxt = CMD_MAX;
    end else begin
      cmd_nxt = rnd[ROUND_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
      prev_temp_r <= '0;
      err_sum_r   <= '0;
    end else begin
      if (rdy0) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
      if (adv0) begin
        have_prev_r <= 1'b1;
        prev_temp_r <= temp0_r;
        err_sum_r   <= err_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      temp0_r <= in_temperature;
    end
    if (rdy1) begin
      stg1_r <= stg1_nxt;
      pos1_r <= pos_nxt;
    end
    if (rdy2) begin
      pos2_r <= pos1_r;
    end
    if (rdy3) begin
      total_r <= total_nxt;
      pos3_r  <= pos2_r;
    end
    if (rdy_out) begin
      out_command_r <= cmd_nxt;
    end
  end

  hpid_product u_product (
    .clk    (clk),
    .load   (rdy2),
    .stg    (stg1_r),
    .gains  (gains_r),
    .prod_r (prod_r)
  );

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;

  `HPID_ASSERT_NOW(a_cmd_range, out_valid_r, out_command_r <= CMD_MAX,
                   "command above full scale")
  `HPID_ASSERT_NOW(a_onoff_levels, out_valid_r && !mode_r,
                   out_command_r == '0 || out_command_r == CMD_ON_OFF,
                   "on/off command level wrong")
  `HPID_ASSERT_NEXT(a_first_sets_prev, adv0, have_prev_r, "previous sample not recorded")
  `HPID_ASSERT_NEXT(a_hot_is_zero, v3_r && rdy_out && !pos3_r, out_command_r == '0,
                    "heating at or above setpoint")

endmodule

// ===== src/hpid_product.sv =====
// Product stage of the regulator: gain times error, integral and derivative.
// Depends on hpid_pkg for the stage structs and widths.
module hpid_product import hpid_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  stg1_t  stg,
  input  gains_t gains,
  output prod_t  prod_r
);

  prod_t                   prod_nxt;
  logic signed [S_HI_W-1:0] s_hi;

  always_comb begin
    s_hi         = stg.s[S_W-1:S_LO_W];
    prod_nxt.pe  = $signed({1'b0, gains.gp}) * stg.e;
    prod_nxt.pd  = $signed({1'b0, gains.gd}) * stg.d;
    prod_nxt.pil = gains.gi * stg.s[S_LO_W-1:0];
    prod_nxt.pih = $signed({1'b0, gains.gi}) * s_hi;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
